// ===== hw/rtl/artu_pkg.sv =====
`timescale 1ns / 1ps

package artu_pkg;

  // Default sizes
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned ClientSlotsDef  = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegAckTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRetries = 2'd1;

  localparam logic [15:0] AckTimeoutRst = 16'd1000;
  localparam logic [3:0]  MaxRetriesRst = 4'd3;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_SENT       = 3'd0,
    K_FULL       = 3'd1,
    K_ACK_MATCH  = 3'd2,
    K_ACK_UNKN   = 3'd3,
    K_RETRANSMIT = 3'd4,
    K_DROP       = 3'd5,
    K_CHECK_DONE = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_KEY,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  // One pending entry as held in the table memory
  typedef struct packed {
    logic [31:0] seq;
    logic [3:0]  client;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [31:0] sent_time;
    logic [3:0]  retries;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Status of the shared subtract/compare unit
  typedef struct packed {
    logic [31:0] diff;
    logic        lt;
    logic        eq;
    logic        over;
  } unit_res_t;

endpackage

// ===== hw/rtl/artu_ram.sv =====
`timescale 1ns / 1ps

module artu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/artu_unit.sv =====
`timescale 1ns / 1ps

// Shared subtract/compare: a - b, borrow, equality and difference above limit.
module artu_unit (
  input  logic [31:0]           a_i,
  input  logic [31:0]           b_i,
  input  logic [15:0]           lim_i,
  output artu_pkg::unit_res_t   res_o
);

  logic [32:0] diff;

  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff = diff[31:0];
  assign res_o.lt   = diff[32];
  assign res_o.eq   = (a_i == b_i);
  assign res_o.over = (diff[31:0] > {16'd0, lim_i});

endmodule

// ===== hw/rtl/ack_retransmit_table_unit.sv =====
`timescale 1ns / 1ps

// Sender-side retransmission table. One item is taken at a time; in_stall_o is
// high from acceptance until the item's work is finished (its last result may
// still wait in the output register while the next item is accepted). All work
// goes through one subtract/compare unit, stepped by the sequencer below, and
// the table is a memory read one slot at a time (address, then compare).
// Steps per item:
//   send  : reduce client_index by repeated CLIENT_SLOTS subtractions (none
//           when client_index is already below CLIENT_SLOTS), read the
//           client's sequence counter, then scan slots up to the matching
//           slot, otherwise all TABLE_ENTRIES;
//   ack   : scan slots as above;
//   check : scan all TABLE_ENTRIES;
// any step that emits a result waits while the output register is stalled.
// A send or ack emits one result; a check emits one retransmit or drop result
// per expired entry, in ascending slot order, then a closing check-done result
// with last set. The per-client sequence counters live in a second memory with
// one reset-cleared valid bit per client, so no clearing pass is needed.
module ack_retransmit_table_unit #(
  parameter int unsigned TABLE_ENTRIES = artu_pkg::TableEntriesDef,
  parameter int unsigned CLIENT_SLOTS  = artu_pkg::ClientSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [31:0]                   now_ms_i,
  input  logic [3:0]                    client_index_i,
  input  logic [7:0]                    payload_handle_i,
  input  logic [9:0]                    payload_length_i,
  input  logic [31:0]                   ack_seq_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    kind_o,
  output logic [31:0]                   seq_o,
  output logic [3:0]                    client_out_o,
  output logic [7:0]                    handle_out_o,
  output logic [9:0]                    length_out_o,
  output logic [3:0]                    retries_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [artu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [artu_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned EA = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CA = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam logic [EA-1:0] LastSlot = EA'(TABLE_ENTRIES - 1);

  // Configuration registers
  logic [15:0] timeout_q;
  logic [3:0]  maxr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= artu_pkg::AckTimeoutRst;
      maxr_q    <= artu_pkg::MaxRetriesRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == artu_pkg::RegAckTimeout) begin
        timeout_q <= cfg_wdata_i;
      end else if (cfg_idx_i == artu_pkg::RegMaxRetries) begin
        maxr_q <= cfg_wdata_i[3:0];
      end
    end
  end

  // Sequencer state and captured item
  artu_pkg::state_e state_q, state_d;
  artu_pkg::op_e    op_q;
  logic [31:0]      now_q;
  logic [3:0]       cl_q;
  logic [7:0]       hd_q;
  logic [9:0]       len_q;
  logic [31:0]      key_q;
  logic [EA-1:0]    ptr_q;
  logic [EA-1:0]    free_q;
  logic             free_found_q;

  logic [TABLE_ENTRIES-1:0] vld_q;
  logic [CLIENT_SLOTS-1:0]  cvld_q;

  logic in_acc;
  assign in_stall_o = (state_q != artu_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Output register
  logic              out_valid_q;
  artu_pkg::kind_e   kind_q;
  logic [31:0]       seq_q;
  logic [3:0]        ocl_q;
  logic [7:0]        ohd_q;
  logic [9:0]        olen_q;
  logic [3:0]        oret_q;
  logic              olast_q;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Memories
  logic [CA-1:0]        cidx;
  logic [31:0]          crdata;
  logic                 cwe;
  artu_pkg::entry_t     erd;
  artu_pkg::entry_t     ewdata;
  logic [EA-1:0]        ewaddr;
  logic                 ewe;

  assign cidx = CA'(cl_q);

  artu_ram #(
    .Width (32),
    .Depth (CLIENT_SLOTS)
  ) u_client_ram (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (cidx),
    .wdata_i (key_q + 32'd1),
    .raddr_i (cidx),
    .rdata_o (crdata)
  );

  artu_ram #(
    .Width (artu_pkg::EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ewaddr),
    .wdata_i (ewdata),
    .raddr_i (ptr_q),
    .rdata_o (erd)
  );

  // Shared compare unit: client reduction, sequence match or age test
  logic [31:0]         ua, ub;
  artu_pkg::unit_res_t ures;

  always_comb begin
    if (state_q == artu_pkg::ST_REDUCE) begin
      ua = 32'(cl_q);
      ub = 32'(CLIENT_SLOTS);
    end else if (op_q == artu_pkg::OP_CHECK) begin
      ua = now_q;
      ub = erd.sent_time;
    end else begin
      ua = erd.seq;
      ub = key_q;
    end
  end

  artu_unit u_unit (
    .a_i   (ua),
    .b_i   (ub),
    .lim_i (timeout_q),
    .res_o (ures)
  );

  // Per-slot decisions
  logic cur_vld, hit, at_last, expired, can_retry, have_slot;
  logic [EA-1:0] tgt;

  assign cur_vld   = vld_q[ptr_q];
  assign hit       = cur_vld && ures.eq;
  assign at_last   = (ptr_q == LastSlot);
  assign expired   = cur_vld && ures.over;
  assign can_retry = (erd.retries < maxr_q);
  assign have_slot = hit || free_found_q || !cur_vld;
  assign tgt       = hit ? ptr_q : (free_found_q ? free_q : ptr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      artu_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (artu_pkg::op_e'(opcode_i))
            artu_pkg::OP_SEND:  state_d = artu_pkg::ST_REDUCE;
            artu_pkg::OP_ACK:   state_d = artu_pkg::ST_READ;
            artu_pkg::OP_CHECK: state_d = artu_pkg::ST_READ;
            artu_pkg::OP_NONE:  state_d = artu_pkg::ST_IDLE;
            default:            state_d = artu_pkg::ST_IDLE;
          endcase
        end
      end
      artu_pkg::ST_REDUCE: begin
        if (ures.lt) begin
          state_d = artu_pkg::ST_KEY;
        end
      end
      artu_pkg::ST_KEY:  state_d = artu_pkg::ST_READ;
      artu_pkg::ST_READ: state_d = artu_pkg::ST_EVAL;
      artu_pkg::ST_EVAL: begin
        if (op_q == artu_pkg::OP_CHECK) begin
          if (!expired || out_free) begin
            state_d = at_last ? artu_pkg::ST_DONE : artu_pkg::ST_READ;
          end
        end else if (hit || at_last) begin
          if (out_free) begin
            state_d = artu_pkg::ST_IDLE;
          end
        end else begin
          state_d = artu_pkg::ST_READ;
        end
      end
      artu_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = artu_pkg::ST_IDLE;
        end
      end
      default: state_d = artu_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic            emit;
  artu_pkg::kind_e ekind;
  logic [31:0]     eseq;
  logic [3:0]      ecl;
  logic [7:0]      ehd;
  logic [9:0]      elen;
  logic [3:0]      eret;
  logic            elast;
  logic            vset, vclr;
  logic [EA-1:0]   vidx;

  always_comb begin
    emit   = 1'b0;
    ekind  = artu_pkg::K_CHECK_DONE;
    eseq   = '0;
    ecl    = '0;
    ehd    = '0;
    elen   = '0;
    eret   = '0;
    elast  = 1'b1;
    ewe    = 1'b0;
    ewaddr = ptr_q;
    ewdata = erd;
    cwe    = 1'b0;
    vset   = 1'b0;
    vclr   = 1'b0;
    vidx   = ptr_q;
    unique case (state_q)
      artu_pkg::ST_EVAL: begin
        if (op_q == artu_pkg::OP_SEND) begin
          if ((hit || at_last) && out_free) begin
            emit = 1'b1;
            eseq = key_q;
            ecl  = cl_q;
            ehd  = hd_q;
            elen = len_q;
            if (have_slot) begin
              // store the entry and advance the client counter
              ekind            = artu_pkg::K_SENT;
              ewe              = 1'b1;
              ewaddr           = tgt;
              ewdata.seq       = key_q;
              ewdata.client    = cl_q;
              ewdata.handle    = hd_q;
              ewdata.length    = len_q;
              ewdata.sent_time = now_q;
              ewdata.retries   = '0;
              cwe              = 1'b1;
              vset             = 1'b1;
              vidx             = tgt;
            end else begin
              ekind = artu_pkg::K_FULL;
            end
          end
        end else if (op_q == artu_pkg::OP_ACK) begin
          if ((hit || at_last) && out_free) begin
            emit = 1'b1;
            eseq = key_q;
            if (hit) begin
              ekind = artu_pkg::K_ACK_MATCH;
              ecl   = erd.client;
              ehd   = erd.handle;
              elen  = erd.length;
              eret  = erd.retries;
              vclr  = 1'b1;
            end else begin
              ekind = artu_pkg::K_ACK_UNKN;
            end
          end
        end else begin
          if (expired && out_free) begin
            emit  = 1'b1;
            elast = 1'b0;
            eseq  = erd.seq;
            ecl   = erd.client;
            ehd   = erd.handle;
            elen  = erd.length;
            if (can_retry) begin
              // resend: bump retries and restart the age
              ekind            = artu_pkg::K_RETRANSMIT;
              eret             = erd.retries + 4'd1;
              ewe              = 1'b1;
              ewdata.retries   = erd.retries + 4'd1;
              ewdata.sent_time = now_q;
            end else begin
              ekind = artu_pkg::K_DROP;
              eret  = erd.retries;
              vclr  = 1'b1;
            end
          end
        end
      end
      artu_pkg::ST_DONE: begin
        if (out_free) begin
          emit  = 1'b1;
          ekind = artu_pkg::K_CHECK_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= artu_pkg::ST_IDLE;
      op_q         <= artu_pkg::OP_NONE;
      ptr_q        <= '0;
      free_found_q <= 1'b0;
      vld_q        <= '0;
      cvld_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        op_q         <= artu_pkg::op_e'(opcode_i);
        ptr_q        <= '0;
        free_found_q <= 1'b0;
      end else if (state_q == artu_pkg::ST_EVAL && state_d == artu_pkg::ST_READ) begin
        ptr_q <= ptr_q + EA'(1);
        // remember the first free slot in case no entry carries this sequence
        if (!cur_vld && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (vset) begin
        vld_q[vidx] <= 1'b1;
      end
      if (vclr) begin
        vld_q[vidx] <= 1'b0;
      end
      if (cwe) begin
        cvld_q[cidx] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= now_ms_i;
      cl_q  <= client_index_i;
      hd_q  <= payload_handle_i;
      len_q <= payload_length_i;
      key_q <= ack_seq_i;
    end else if (state_q == artu_pkg::ST_REDUCE && !ures.lt) begin
      // drop one CLIENT_SLOTS from the client index
      cl_q <= ures.diff[3:0];
    end else if (state_q == artu_pkg::ST_KEY) begin
      key_q <= cvld_q[cidx] ? crdata : 32'd0;
    end
    if (state_q == artu_pkg::ST_EVAL && state_d == artu_pkg::ST_READ &&
        !cur_vld && !free_found_q) begin
      free_q <= ptr_q;
    end
    if (emit) begin
      kind_q  <= ekind;
      seq_q   <= eseq;
      ocl_q   <= ecl;
      ohd_q   <= ehd;
      olen_q  <= elen;
      oret_q  <= eret;
      olast_q <= elast;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign seq_o        = seq_q;
  assign client_out_o = ocl_q;
  assign handle_out_o = ohd_q;
  assign length_out_o = olen_q;
  assign retries_o    = oret_q;
  assign last_o       = olast_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the retransmission table. Items are driven at the falling
// edge and every handshake is sampled at the rising edge. Each accepted item
// runs through a shadow copy of the table, and the events it must produce
// are queued. Each event that leaves the block is checked field by field
// against the oldest queued event.
module tb_top;
  import artu_pkg::*;

  localparam int unsigned Slots   = TableEntriesDef;
  localparam int unsigned Clients = ClientSlotsDef;
  // Idle time long enough for a check to walk every slot, with margin on top.
  localparam int          IdleSettle = 2 * Slots + 8;
  localparam int          CycleLimit = 400000;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

  // One event leaving the block.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [3:0]  client;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [3:0]  retries;
    logic        last;
  } retx_event_t;

  // One row of directed stimulus; 'typed' rows carry their event by hand.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [3:0]  client;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [31:0] ack;
    logic        typed;
    retx_event_t want;
  } plan_row_t;

  // Shadow copy of one table slot.
  typedef struct packed {
    logic        busy;
    logic [31:0] seq;
    logic [3:0]  client;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [31:0] stamp;
    logic [3:0]  tries;
  } pend_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [31:0] now_ms_i;
  logic [3:0]  client_index_i;
  logic [7:0]  payload_handle_i;
  logic [9:0]  payload_length_i;
  logic [31:0] ack_seq_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [31:0] seq_o;
  logic [3:0]  client_out_o;
  logic [7:0]  handle_out_o;
  logic [9:0]  length_out_o;
  logic [3:0]  retries_o;
  logic        last_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ack_retransmit_table_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .now_ms_i         (now_ms_i),
    .client_index_i   (client_index_i),
    .payload_handle_i (payload_handle_i),
    .payload_length_i (payload_length_i),
    .ack_seq_i        (ack_seq_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .seq_o            (seq_o),
    .client_out_o     (client_out_o),
    .handle_out_o     (handle_out_o),
    .length_out_o     (length_out_o),
    .retries_o        (retries_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // Shadow state of the block
  pend_t       pend_slot [Slots];
  logic [31:0] next_seq_of [Clients];
  logic [15:0] cfg_timeout;
  logic [3:0]  cfg_retry_limit;

  retx_event_t awaited_events[$];
  int          mismatches;
  int          cycle_no;

  // Handoff from the driver for hand-typed rows
  logic        typed_armed;
  retx_event_t typed_want;

  // Sender burst bookkeeping and the stimulus clock
  int          burst_left;
  logic [31:0] wall_ms;

  plan_row_t   plan [15];

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  function automatic int slot_of(input logic [31:0] s);
    for (int k = 0; k < Slots; k++) begin
      if (pend_slot[k].busy && pend_slot[k].seq == s) return k;
    end
    return -1;
  endfunction

  function automatic retx_event_t make_event(input kind_e kd, input logic [31:0] s,
                                             input logic [3:0] cl, input logic [7:0] hd,
                                             input logic [9:0] len, input logic [3:0] rt,
                                             input logic lst);
    retx_event_t ev;
    ev.kind    = kd;
    ev.seq     = s;
    ev.client  = cl;
    ev.handle  = hd;
    ev.length  = len;
    ev.retries = rt;
    ev.last    = lst;
    return ev;
  endfunction

  // Append one event to the tail of the awaited list.
  task automatic queue_event(input retx_event_t ev);
    awaited_events = {awaited_events, ev};
  endtask

  // Advance the shadow table by one item and queue the events it produces.
  task automatic apply_item(input logic [1:0] op, input logic [31:0] now,
                            input logic [3:0] cl, input logic [7:0] hd,
                            input logic [9:0] len, input logic [31:0] aseq);
    int          hit;
    logic [31:0] s;
    logic [31:0] age;
    case (op)
      OP_SEND: begin
        s   = next_seq_of[cl];
        hit = slot_of(s);
        // reuse a slot holding the same sequence, else take the lowest free one
        if (hit < 0) begin
          for (int k = Slots - 1; k >= 0; k--) begin
            if (!pend_slot[k].busy) hit = k;
          end
        end
        if (hit < 0) begin
          queue_event(make_event(K_FULL, s, cl, hd, len, 4'd0, 1'b1));
        end else begin
          next_seq_of[cl] = s + 32'd1;
          pend_slot[hit]  = '{1'b1, s, cl, hd, len, now, 4'd0};
          queue_event(make_event(K_SENT, s, cl, hd, len, 4'd0, 1'b1));
        end
      end
      OP_ACK: begin
        hit = slot_of(aseq);
        if (hit < 0) begin
          queue_event(make_event(K_ACK_UNKN, aseq, 4'd0, 8'd0, 10'd0, 4'd0, 1'b1));
        end else begin
          pend_slot[hit].busy = 1'b0;
          queue_event(make_event(K_ACK_MATCH, aseq, pend_slot[hit].client,
                                 pend_slot[hit].handle, pend_slot[hit].length,
                                 pend_slot[hit].tries, 1'b1));
        end
      end
      OP_CHECK: begin
        for (int k = 0; k < Slots; k++) begin
          age = now - pend_slot[k].stamp;
          if (pend_slot[k].busy && age > {16'd0, cfg_timeout}) begin
            if (pend_slot[k].tries < cfg_retry_limit) begin
              pend_slot[k].tries = pend_slot[k].tries + 4'd1;
              pend_slot[k].stamp = now;
              queue_event(make_event(K_RETRANSMIT, pend_slot[k].seq,
                                     pend_slot[k].client, pend_slot[k].handle,
                                     pend_slot[k].length, pend_slot[k].tries, 1'b0));
            end else begin
              pend_slot[k].busy = 1'b0;
              queue_event(make_event(K_DROP, pend_slot[k].seq,
                                     pend_slot[k].client, pend_slot[k].handle,
                                     pend_slot[k].length, pend_slot[k].tries, 1'b0));
            end
          end
        end
        queue_event(make_event(K_CHECK_DONE, 32'd0, 4'd0, 8'd0, 10'd0, 4'd0, 1'b1));
      end
      default: ;  // unused opcode: no change, no event
    endcase
  endtask

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Rising-edge monitor: clear the shadow table during reset; afterwards take
  // accepted items into the shadow table first, then check whatever event
  // leaves the block at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    retx_event_t ev;
    cycle_no++;
    if (cycle_no > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end else if (!rst_ni) begin
      for (int k = 0; k < Slots; k++) pend_slot[k] = '0;
      for (int k = 0; k < Clients; k++) next_seq_of[k] = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_item(opcode_i, now_ms_i, client_index_i, payload_handle_i, payload_length_i,
                   ack_seq_i);
        // a hand-typed row replaces the single event just queued
        if (typed_armed) begin
          awaited_events[awaited_events.size() - 1] = typed_want;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_events.size() == 0) begin
          flag("event with nothing awaited, kind", {29'd0, kind_o}, 32'd0);
        end else begin
          ev = awaited_events.pop_front();
          if (kind_o != ev.kind) flag("kind", {29'd0, kind_o}, {29'd0, ev.kind});
          if (seq_o != ev.seq) flag("seq", seq_o, ev.seq);
          if (client_out_o != ev.client) flag("client", {28'd0, client_out_o}, {28'd0, ev.client});
          if (handle_out_o != ev.handle) flag("handle", {24'd0, handle_out_o}, {24'd0, ev.handle});
          if (length_out_o != ev.length) flag("length", {22'd0, length_out_o}, {22'd0, ev.length});
          if (retries_o != ev.retries) flag("retries", {28'd0, retries_o}, {28'd0, ev.retries});
          if (last_o != ev.last) flag("last", {31'd0, last_o}, {31'd0, ev.last});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns at random intervals, including
  // spans with no stall at all.
  // ---------------------------------------------------------------------------
  int stall_mode;
  int stall_span;
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 80);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall_i = 1'b0;
      1:       out_stall_i = ($urandom_range(0, 3) == 0);
      2:       out_stall_i = ($urandom_range(0, 3) != 0);
      default: out_stall_i = ((cycle_no % 5) < 2);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Gaps fall only
  // between bursts, so valid stays high through a burst.
  task automatic offer(input plan_row_t r);
    int gap;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    opcode_i         = r.op;
    now_ms_i         = r.now;
    client_index_i   = r.client;
    payload_handle_i = r.handle;
    payload_length_i = r.length;
    ack_seq_i        = r.ack;
    typed_want       = r.want;
    typed_armed      = r.typed;
    in_valid_i       = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Park the sender, drain every awaited event, then let a full scan finish.
  task automatic settle();
    in_valid_i = 1'b0;
    while (awaited_events.size() != 0) @(negedge clk_i);
    repeat (IdleSettle) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      RegAckTimeout: cfg_timeout     = data;
      RegMaxRetries: cfg_retry_limit = data[3:0];
      default: ;
    endcase
  endtask

  function automatic plan_row_t noise_row(input logic [1:0] op);
    plan_row_t r;
    r.op     = op;
    r.now    = $urandom();
    r.client = 4'($urandom_range(0, 15));
    r.handle = 8'($urandom_range(0, 255));
    r.length = 10'($urandom_range(0, 1023));
    r.ack    = $urandom();
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // Mostly well-formed traffic: sends, acks of pending sequences and checks on
  // a clock that moves at a pace tied to the timeout. The rest is noise:
  // unknown acks, stale acks, wild timestamps and the unused opcode.
  task automatic traffic(input int count, input bit flood);
    plan_row_t   r;
    int          sent_items;
    int          pick;
    int          n_busy;
    int          step;
    logic [3:0]  cl;
    logic [31:0] pool [Slots];
    step = int'(cfg_timeout) / 3 + 2;
    // flood one client past capacity to reach a full table
    if (flood) begin
      cl = 4'($urandom_range(0, 15));
      repeat (Slots + 2) begin
        wall_ms  = wall_ms + $urandom_range(0, step);
        r        = noise_row(OP_SEND);
        r.client = cl;
        r.now    = wall_ms;
        offer(r);
      end
    end
    sent_items = 0;
    while (sent_items < count) begin
      pick    = $urandom_range(0, 99);
      wall_ms = wall_ms + $urandom_range(0, step);
      r       = noise_row(OP_SEND);
      r.now   = ($urandom_range(0, 29) == 0) ? $urandom() : wall_ms;
      if (pick < 45) begin
        r.op = OP_SEND;
      end else if (pick < 72) begin
        r.op   = OP_ACK;
        n_busy = 0;
        for (int k = 0; k < Slots; k++) begin
          if (pend_slot[k].busy) begin
            pool[n_busy] = pend_slot[k].seq;
            n_busy++;
          end
        end
        if (n_busy > 0) r.ack = pool[$urandom_range(0, n_busy - 1)];
      end else if (pick < 77) begin
        r.op = OP_ACK;
      end else if (pick < 80) begin
        r.op  = OP_ACK;
        r.ack = next_seq_of[$urandom_range(0, 15)] - 32'd1;
      end else if (pick < 96) begin
        r.op = OP_CHECK;
      end else begin
        r.op = OP_NONE;
      end
      offer(r);
      if (r.op != OP_NONE) sent_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [15:0] junk;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_NONE;
    now_ms_i         = '0;
    client_index_i   = '0;
    payload_handle_i = '0;
    payload_length_i = '0;
    ack_seq_i        = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegAckTimeout;
    cfg_wdata_i      = '0;
    typed_armed      = 1'b0;
    typed_want       = '0;
    burst_left       = 0;
    wall_ms          = '0;
    cfg_timeout      = AckTimeoutRst;
    cfg_retry_limit  = MaxRetriesRst;

    // Directed rows, under the reset settings (timeout 1000, three retries).
    // fresh table: client 0 takes sequence 0
    plan[0]  = '{OP_SEND, 32'h0, 4'd0, 8'hFF, 10'h3FF, 32'h0, 1'b1,
                 '{K_SENT, 32'h0, 4'd0, 8'hFF, 10'h3FF, 4'd0, 1'b1}};
    // client 15 also starts at 0, so it overwrites the pending entry
    plan[1]  = '{OP_SEND, 32'd10, 4'd15, 8'h00, 10'h000, 32'h0, 1'b1,
                 '{K_SENT, 32'h0, 4'd15, 8'h00, 10'h000, 4'd0, 1'b1}};
    plan[2]  = '{OP_ACK, 32'd15, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    plan[3]  = '{OP_ACK, 32'd16, 4'd0, 8'd0, 10'd0, 32'hFFFF_FFFF, 1'b1,
                 '{K_ACK_UNKN, 32'hFFFF_FFFF, 4'd0, 8'd0, 10'd0, 4'd0, 1'b1}};
    // empty table: the closing event is the only one
    plan[4]  = '{OP_CHECK, 32'd20, 4'd0, 8'd0, 10'd0, 32'h0, 1'b1,
                 '{K_CHECK_DONE, 32'h0, 4'd0, 8'd0, 10'd0, 4'd0, 1'b1}};
    plan[5]  = '{OP_NONE, 32'hFFFF_FFFF, 4'd15, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, 1'b0, '0};
    // two entries stamped just before the time counter wraps
    plan[6]  = '{OP_SEND, 32'hFFFF_FF00, 4'd1, 8'h5A, 10'd200, 32'h0, 1'b0, '0};
    plan[7]  = '{OP_SEND, 32'hFFFF_FF80, 4'd0, 8'hA5, 10'd1, 32'h0, 1'b0, '0};
    // age exactly at the timeout: not yet expired
    plan[8]  = '{OP_CHECK, 32'h0000_02E8, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    // one past the timeout, then retransmit until the limit, then drop
    plan[9]  = '{OP_CHECK, 32'h0000_02E9, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    plan[10] = '{OP_CHECK, 32'h0000_06D2, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    plan[11] = '{OP_CHECK, 32'h0000_0ABB, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    plan[12] = '{OP_CHECK, 32'h0000_0EA4, 4'd0, 8'd0, 10'd0, 32'h0, 1'b0, '0};
    // ack of an entry that has been retransmitted: reports its retry count
    plan[13] = '{OP_ACK, 32'h0000_0EA5, 4'd0, 8'd0, 10'd0, 32'h1, 1'b0, '0};
    plan[14] = '{OP_CHECK, 32'hFFFF_FFFF, 4'd0, 8'd0, 10'd0, 32'h0, 1'b1,
                 '{K_CHECK_DONE, 32'h0, 4'd0, 8'd0, 10'd0, 4'd0, 1'b1}};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 15; i++) offer(plan[i]);

    // reset settings, starting from a full table
    settle();
    wall_ms = 32'h0000_1000;
    traffic(40, 1'b1);

    // timeout of one, no retries; spare indexes must have no effect
    settle();
    junk = 16'($urandom());
    set_reg(RegAckTimeout, 16'd1);
    set_reg(RegMaxRetries, {junk[15:4], 4'd0});
    set_reg(RegSpareA, 16'($urandom()));
    set_reg(RegSpareB, 16'($urandom()));
    traffic(35, 1'b1);

    // longest timeout, most retries
    settle();
    junk = 16'($urandom());
    set_reg(RegAckTimeout, 16'hFFFF);
    set_reg(RegMaxRetries, {junk[15:4], 4'd15});
    traffic(35, 1'b0);

    // random settings with the clock running across its wrap
    settle();
    junk = 16'($urandom());
    set_reg(RegAckTimeout, 16'($urandom_range(1, 3000)));
    set_reg(RegMaxRetries, {junk[15:4], 4'($urandom_range(0, 15))});
    wall_ms = 32'hFFFF_F000;
    traffic(35, 1'b1);

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/artu_pkg.sv
hw/rtl/artu_ram.sv
hw/rtl/artu_unit.sv
hw/rtl/ack_retransmit_table_unit.sv
verif/tb_top.sv
